// File: hw/rtl/bfdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_pkg: shared types and constants
// Widths, limits, register indexes and controller states of the Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    localparam int MAX_BITS   = 65536;
    localparam int MAX_PROBES = 30;
    localparam int ADDR_W     = $clog2(MAX_BITS);
    localparam int NBITS_W    = 17;
    localparam int PROBES_W   = 5;
    localparam int HASH_W     = 64;
    localparam int CFG_W      = 17;
    localparam int IDX_W      = 1;

    localparam logic [IDX_W-1:0] REG_BITS_IN_USE = 1'b0;
    localparam logic [IDX_W-1:0] REG_PROBE_COUNT = 1'b1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Request from the controller to the remainder unit.
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [ADDR_W:0]   modulus;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] rem;
    } mod_rsp_t;

endpackage

// File: hw/rtl/bfdh_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_mod_unit: 64-bit remainder by the modulus
// Restoring remainder, two dividend bits per cycle.
// ----------------------------------------------------------------------------
module bfdh_mod_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfdh_pkg::mod_req_t req,
    output bfdh_pkg::mod_rsp_t rsp
);

    localparam int RW = bfdh_pkg::ADDR_W + 1;
    localparam int CW = $clog2(bfdh_pkg::HASH_W / 2 + 1);

    logic [bfdh_pkg::HASH_W-1:0] shf_reg, shf_next;
    logic [RW-1:0]               rem_reg, rem_next;
    logic [RW-1:0]               mod_reg, mod_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [RW:0]                 t1, t2;
    logic [RW-1:0]               r1;

    always_comb
    begin
        // Two restoring steps; remainder stays below the modulus (at most 2^16).
        t1 = {rem_reg, shf_reg[bfdh_pkg::HASH_W-1]};
        r1 = (t1 >= {1'b0, mod_reg}) ? RW'(t1 - {1'b0, mod_reg}) : RW'(t1);
        t2 = {r1, shf_reg[bfdh_pkg::HASH_W-2]};
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            shf_next  = req.dividend;
            rem_next  = '0;
            mod_next  = req.modulus;
            cnt_next  = CW'(bfdh_pkg::HASH_W / 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            shf_next = {shf_reg[bfdh_pkg::HASH_W-3:0], 2'b00};
            rem_next = (t2 >= {1'b0, mod_reg}) ? RW'(t2 - {1'b0, mod_reg}) : RW'(t2);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shf_reg <= shf_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[bfdh_pkg::ADDR_W-1:0];

endmodule

// File: hw/rtl/bfdh_bit_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_bit_store: filter bit memory
// One-bit-wide synchronous RAM with a registered read and a clear sweep.
// ----------------------------------------------------------------------------
module bfdh_bit_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bfdh_pkg::ADDR_W-1:0] wr_addr,
    input  logic [bfdh_pkg::ADDR_W-1:0] rd_addr,
    output logic                        rd_data,
    output logic                        ready
);

    logic                        mem [bfdh_pkg::MAX_BITS];
    logic [bfdh_pkg::ADDR_W-1:0] clr_reg, clr_next;
    logic                        clr_busy_reg, clr_busy_next;
    logic                        we;
    logic [bfdh_pkg::ADDR_W-1:0] wa;
    logic                        wd;

    always_comb
    begin
        clr_next      = clr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == {bfdh_pkg::ADDR_W{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
        we = clr_busy_reg | wr_en;
        wa = clr_busy_reg ? clr_reg : wr_addr;
        wd = !clr_busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data <= mem[rd_addr];
    end

    assign ready = !clr_busy_reg;

endmodule

// File: hw/rtl/bloom_filter_double_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_core: Bloom filter with double-hash probing
// Adds keys to or queries keys in a 65536-bit filter store.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Handshake
//  request   start, opcode, hash_a, hash_b    accepted when start && !busy
//  result    done, may_contain                one-cycle strobe, cannot stall
//  config    cfg_we, cfg_idx, cfg_data        written on any edge with cfg_we
//
// Each probe goes through the shared remainder unit (32 two-bit steps
// plus its registered done flag), then a memory read and a check. A new
// request is accepted only once the last item is done; a query ends
// early at its first clear bit. After reset the store is swept clear over
// all 65536 addresses with busy high; configuration writes are still
// taken. The result strobe lasts one cycle and the receiver cannot hold it.
module bloom_filter_double_hash_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [bfdh_pkg::HASH_W-1:0]   hash_a,
    input  logic [bfdh_pkg::HASH_W-1:0]   hash_b,
    output logic                          done,
    output logic                          may_contain,
    input  logic                          cfg_we,
    input  logic [bfdh_pkg::IDX_W-1:0]    cfg_idx,
    input  logic [bfdh_pkg::CFG_W-1:0]    cfg_data
);

    bfdh_pkg::state_t            st_reg, st_next;
    logic [bfdh_pkg::NBITS_W-1:0]  nbits_reg;
    logic [bfdh_pkg::PROBES_W-1:0] nprobe_reg;
    logic                        op_reg, op_next;
    logic [bfdh_pkg::HASH_W-1:0] pos_reg, pos_next;
    logic [bfdh_pkg::HASH_W-1:0] stride_reg, stride_next;
    logic [bfdh_pkg::PROBES_W-1:0] left_reg, left_next;
    logic [bfdh_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        done_reg, done_next;
    logic                        ans_reg, ans_next;
    logic [bfdh_pkg::ADDR_W:0]   eff_bits;
    logic [bfdh_pkg::PROBES_W-1:0] eff_probes;
    bfdh_pkg::mod_req_t          mreq;
    bfdh_pkg::mod_rsp_t          mrsp;
    logic                        wr_en;
    logic                        rd_bit;
    logic                        store_ready;

    // Clamp the registers to their usable ranges.
    always_comb
    begin
        if (nbits_reg == '0)
            eff_bits = (bfdh_pkg::ADDR_W+1)'(1);
        else if (nbits_reg > bfdh_pkg::NBITS_W'(bfdh_pkg::MAX_BITS))
            eff_bits = (bfdh_pkg::ADDR_W+1)'(bfdh_pkg::MAX_BITS);
        else
            eff_bits = (bfdh_pkg::ADDR_W+1)'(nbits_reg);
        if (nprobe_reg == '0)
            eff_probes = bfdh_pkg::PROBES_W'(1);
        else if (nprobe_reg > bfdh_pkg::PROBES_W'(bfdh_pkg::MAX_PROBES))
            eff_probes = bfdh_pkg::PROBES_W'(bfdh_pkg::MAX_PROBES);
        else
            eff_probes = nprobe_reg;
    end

    // Controller: remainder, read, then check/write; the running probe
    // position is kept as a 64-bit sum so it wraps like the hash arithmetic.
    always_comb
    begin
        st_next     = st_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        stride_next = stride_reg;
        left_next   = left_reg;
        addr_next   = addr_reg;
        ans_next    = ans_reg;
        done_next   = 1'b0;
        mreq.start    = 1'b0;
        mreq.dividend = pos_reg;
        mreq.modulus  = eff_bits;
        wr_en       = 1'b0;
        case (st_reg)
            bfdh_pkg::ST_IDLE:
            begin
                if (start && store_ready)
                begin
                    op_next     = opcode;
                    pos_next    = hash_a;
                    stride_next = hash_b;
                    left_next   = eff_probes;
                    ans_next    = 1'b1;
                    st_next     = bfdh_pkg::ST_MOD;
                    mreq.start    = 1'b1;
                    mreq.dividend = hash_a;
                end
            end
            bfdh_pkg::ST_MOD:
            begin
                if (mrsp.done)
                begin
                    addr_next = mrsp.rem;
                    pos_next  = pos_reg + stride_reg;
                    left_next = left_reg - 1'b1;
                    st_next   = bfdh_pkg::ST_READ;
                end
            end
            bfdh_pkg::ST_READ:
            begin
                st_next = bfdh_pkg::ST_CHECK;
            end
            bfdh_pkg::ST_CHECK:
            begin
                if (op_reg == bfdh_pkg::OP_ADD)
                begin
                    wr_en = 1'b1;
                end
                if (op_reg == bfdh_pkg::OP_QUERY && !rd_bit)
                begin
                    ans_next = 1'b0;
                    st_next  = bfdh_pkg::ST_DONE;
                end
                else if (left_reg == '0)
                begin
                    st_next = bfdh_pkg::ST_DONE;
                end
                else
                begin
                    mreq.start = 1'b1;
                    st_next    = bfdh_pkg::ST_MOD;
                end
            end
            bfdh_pkg::ST_DONE:
            begin
                done_next = 1'b1;
                st_next   = bfdh_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = bfdh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= bfdh_pkg::ST_IDLE;
            done_reg   <= 1'b0;
            nbits_reg  <= bfdh_pkg::NBITS_W'(65536);
            nprobe_reg <= bfdh_pkg::PROBES_W'(7);
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            if (cfg_we && cfg_idx == bfdh_pkg::REG_BITS_IN_USE)
                nbits_reg <= cfg_data[bfdh_pkg::NBITS_W-1:0];
            if (cfg_we && cfg_idx == bfdh_pkg::REG_PROBE_COUNT)
                nprobe_reg <= cfg_data[bfdh_pkg::PROBES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        stride_reg <= stride_next;
        left_reg   <= left_next;
        addr_reg   <= addr_next;
        ans_reg    <= ans_next;
    end

    bfdh_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    bfdh_bit_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .rd_addr (addr_reg),
        .rd_data (rd_bit),
        .ready   (store_ready)
    );

    assign busy        = (st_reg != bfdh_pkg::ST_IDLE) || !store_ready;
    assign done        = done_reg;
    assign may_contain = done_reg & (op_reg == bfdh_pkg::OP_QUERY) & ans_reg;

endmodule
